[sv/wpa_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wpa_pkg
// Shared constants and types of the waveform pulse analyzer.
// ---------------------------------------------------------------------------
package wpa_pkg;
	localparam int SampleBits = 12;
	localparam int HistDepth = 1 << SampleBits;
	localparam int HistAw = SampleBits;
	localparam int IdxBits = 14;
	localparam int CntBits = 15;
	localparam int SumBits = 27;
	localparam int MaxPoints = 1 << IdxBits;

	localparam logic [2:0] RegMode = 3'd0;
	localparam logic [2:0] RegPreEnd = 3'd1;
	localparam logic [2:0] RegGateFirst = 3'd2;
	localparam logic [2:0] RegGateFinal = 3'd3;
	localparam logic [2:0] RegTimeStep = 3'd4;

	// record summary handed from the accumulator to the finisher
	typedef struct packed {
		logic                       mode;
		logic signed [SumBits-1:0]  pre_sum;
		logic [CntBits-1:0]         pre_cnt;
		logic signed [11:0]         vmin;
		logic signed [11:0]         vmax;
		logic [IdxBits-1:0]         imin;
		logic [IdxBits-1:0]         imax;
		logic signed [SumBits-1:0]  gate_sum;
		logic [CntBits-1:0]         gate_cnt;
		logic [23:0]                tstep;
	} rec_sum_t;
endpackage
`default_nettype wire

[sv/wpa_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wpa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module wpa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(Depth)-1:0]  waddr,
	input  wire [Width-1:0]          wdata,
	input  wire [$clog2(Depth)-1:0]  raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/wpa_div.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wpa_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
module wpa_div import wpa_pkg::*; (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire signed [SumBits+3:0]   num,
	input  wire [CntBits-1:0]          den,
	output logic                       done,
	output logic signed [SumBits+3:0]  quo
);
	localparam int NB = SumBits + 4;
	localparam int CB = $clog2(NB + 1);
	logic [NB-1:0] q_q;
	logic [NB-1:0] n_q;
	logic [CntBits:0] r_q;
	logic [CntBits-1:0] d_q;
	logic neg_q, busy_q;
	logic [CB-1:0] cnt_q;
	logic [CntBits:0] rs;
	logic [CntBits:0] rd;

	assign rs = {r_q[CntBits-1:0], n_q[NB-1]};
	assign rd = rs - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CB'(NB);
				n_q <= num[NB-1] ? NB'(-num) : NB'(num);
				neg_q <= num[NB-1];
				d_q <= den;
				r_q <= '0;
				q_q <= '0;
			end else if (busy_q) begin
				n_q <= {n_q[NB-2:0], 1'b0};
				if (!rd[CntBits]) begin
					r_q <= rd;
					q_q <= {q_q[NB-2:0], 1'b1};
				end else begin
					r_q <= rs;
					q_q <= {q_q[NB-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule
`default_nettype wire

[sv/wpa_finish.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// wpa_finish
// End-of-record math: baseline, amplitude, peak-to-peak, gated integral.
// ---------------------------------------------------------------------------
module wpa_finish import wpa_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  rec_sum_t            rs,
	input  wire                 mode_valid,
	input  wire [HistAw-1:0]    mode_code,
	output logic                done,
	output logic [119:0]        res
);
	typedef enum logic [3:0] {
		F_IDLE, F_WAIT, F_BASE, F_AMP, F_MUL0, F_MUL1, F_MUL2, F_SAT, F_OUT
	} fstate_t;
	fstate_t st_q;
	rec_sum_t r_q;
	logic signed [15:0] base_q;
	logic signed [SumBits+3:0] dnum;
	logic dstart, ddone;
	logic signed [SumBits+3:0] dquo;
	logic signed [19:0] dmin, dmax;
	logic [19:0] amin, amax;
	logic [15:0] amp_q;
	logic [IdxBits-1:0] aidx_q;
	logic signed [47:0] sq4_q;
	logic [46:0] mag_q;
	logic [71:0] prod_q;
	logic [55:0] integ_q;
	logic [47:0] p0_q, p1_q;
	logic signed [31:0] gmul;

	assign dnum = {r_q.pre_sum, 4'b0};
	wpa_div u_div (.clk, .arst_n, .start(dstart), .num(dnum), .den(r_q.pre_cnt),
		.done(ddone), .quo(dquo));

	assign dmin = 20'(base_q) - 20'($signed({r_q.vmin, 4'b0}));
	assign dmax = 20'(base_q) - 20'($signed({r_q.vmax, 4'b0}));
	assign amin = dmin[19] ? 20'(-dmin) : 20'(dmin);
	assign amax = dmax[19] ? 20'(-dmax) : 20'(dmax);
	assign gmul = $signed({1'b0, r_q.gate_cnt}) * base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			done <= 1'b0;
			dstart <= 1'b0;
		end else begin
			done <= 1'b0;
			dstart <= 1'b0;
			unique case (st_q)
				F_IDLE: if (start) begin
					r_q <= rs;
					st_q <= F_WAIT;
					if (!rs.mode && rs.pre_cnt != '0) dstart <= 1'b1;
				end
				F_WAIT: begin
					if (r_q.pre_cnt == '0) begin
						base_q <= '0;
						if (!r_q.mode || mode_valid) st_q <= F_BASE;
					end else if (r_q.mode) begin
						if (mode_valid) begin
							base_q <= {~mode_code[HistAw-1], mode_code[HistAw-2:0], 4'b0};
							st_q <= F_BASE;
						end
					end else if (ddone) begin
						base_q <= dquo[15:0];
						st_q <= F_BASE;
					end
				end
				F_BASE: begin
					if (amin > amax) begin
						amp_q <= amin[15:0]; aidx_q <= r_q.imin;
					end else begin
						amp_q <= amax[15:0];
						aidx_q <= (amin == amax && r_q.imin > r_q.imax) ? r_q.imin : r_q.imax;
					end
					st_q <= F_AMP;
				end
				F_AMP: begin
					sq4_q <= 48'(gmul) - 48'($signed({r_q.gate_sum, 4'b0}));
					st_q <= F_MUL0;
				end
				F_MUL0: begin
					mag_q <= sq4_q[47] ? 47'(-sq4_q) : 47'(sq4_q);
					st_q <= F_MUL1;
				end
				F_MUL1: begin
					p0_q <= 48'(mag_q[23:0] * r_q.tstep);
					p1_q <= 48'(mag_q[46:24] * r_q.tstep);
					st_q <= F_MUL2;
				end
				F_MUL2: begin
					prod_q <= 72'(p0_q) + {p1_q, 24'b0};
					st_q <= F_SAT;
				end
				F_SAT: begin
					if (prod_q > 72'h007F_FFFF_FFFF_FFFF)
						integ_q <= sq4_q[47] ? 56'h80_0000_0000_0000 : 56'h7F_FFFF_FFFF_FFFF;
					else
						integ_q <= sq4_q[47] ? 56'(-prod_q[55:0]) : prod_q[55:0];
					st_q <= F_OUT;
				end
				F_OUT: begin
					done <= 1'b1;
					res <= {5'b0, (r_q.pre_cnt == '0), integ_q,
						12'(r_q.vmax - r_q.vmin), aidx_q, amp_q, base_q};
					st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/waveform_pulse_analyzer.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// waveform_pulse_analyzer
// Pulse height, baseline and gated charge of one digitizer record.
// ---------------------------------------------------------------------------
// Samples stream in one per cycle within a record. The
// pretrigger code histogram lives in a 4096 x 15 RAM updated read-modify-write
// with forwarding from the two writes still in flight. At the end of a record
// the block stops taking samples while it sweeps the whole histogram, finding
// the mode and clearing each entry, and the finisher works out the baseline
// (with the divider in average mode) and the integral. After reset a clearing
// pass over all 4096 entries runs before the first sample is accepted. Results
// leave through an output register.
module waveform_pulse_analyzer import wpa_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire [2:0]    cfg_index,
	input  wire [23:0]   cfg_data,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire [15:0]   s_tdata,   // [11:0] sample
	input  wire          s_tlast,   // record_end
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [119:0] m_tdata    // baseline_q4, amplitude_q4, amplitude_index,
	                                // peak_to_peak, gated_integral, pretrigger_empty
);
	typedef enum logic [2:0] {S_CLR, S_RUN, S_SCAN, S_FIN, S_OUT} state_t;
	state_t st_q;

	logic mode_q;
	logic [14:0] pre_end_q;
	logic [13:0] gfirst_q, gfinal_q;
	logic [23:0] tstep_q;

	logic [IdxBits:0] idx_q;
	logic signed [SumBits-1:0] psum_q, gsum_q;
	logic [CntBits-1:0] pcnt_q, gcnt_q;
	logic signed [11:0] vmin_q, vmax_q;
	logic [IdxBits-1:0] imin_q, imax_q;

	// histogram ram
	logic we;
	logic [HistAw-1:0] waddr, raddr;
	logic [CntBits-1:0] wdata, rdata;
	wpa_ram #(.Width(CntBits), .Depth(HistDepth)) u_hist (
		.clk, .we, .waddr, .wdata, .raddr, .rdata);

	// pipeline of the histogram increment
	logic inc_s1;
	logic [HistAw-1:0] addr_s1;
	logic inc_s2;
	logic [HistAw-1:0] addr_s2;
	logic [CntBits-1:0] val_s2;
	logic inc_s3;
	logic [HistAw-1:0] addr_s3;
	logic [CntBits-1:0] val_s3;
	logic [CntBits-1:0] cur_s1;

	logic [HistAw:0] sweep_q;
	logic scan_rd_s1;
	logic [HistAw-1:0] scan_a_s1;
	logic [CntBits-1:0] best_cnt_q;
	logic [HistAw-1:0] best_code_q;
	logic mode_valid_q;

	logic fin_start_q, fin_done;
	logic [119:0] fin_res;
	rec_sum_t rs;

	logic acc;
	logic signed [11:0] v;
	logic [IdxBits-1:0] i;
	logic in_pre, in_gate;

	assign s_tready = (st_q == S_RUN);
	assign acc = s_tvalid && s_tready;
	assign v = $signed(s_tdata[11:0]);
	assign i = idx_q[IdxBits-1:0];
	assign in_pre = !idx_q[IdxBits] && ({1'b0, i} < pre_end_q);
	assign in_gate = !idx_q[IdxBits] && i >= gfirst_q && i <= gfinal_q;

	// forward the entries written this cycle and last cycle; the ram read
	// launched on the write edge still returns the old count
	assign cur_s1 = (inc_s2 && addr_s2 == addr_s1) ? val_s2 :
		(inc_s3 && addr_s3 == addr_s1) ? val_s3 : rdata;

	always_comb begin
		raddr = {~s_tdata[11], s_tdata[10:0]};
		we = 1'b0;
		waddr = addr_s2;
		wdata = val_s2;
		if (st_q == S_SCAN) raddr = sweep_q[HistAw-1:0];
		if (inc_s2) begin
			we = 1'b1;
		end else if (scan_rd_s1 || st_q == S_CLR) begin
			we = 1'b1;
			waddr = (st_q == S_CLR) ? sweep_q[HistAw-1:0] : scan_a_s1;
			wdata = '0;
		end
	end

	assign rs = '{mode: mode_q, pre_sum: psum_q, pre_cnt: pcnt_q, vmin: vmin_q,
		vmax: vmax_q, imin: imin_q, imax: imax_q, gate_sum: gsum_q,
		gate_cnt: gcnt_q, tstep: tstep_q};

	wpa_finish u_fin (.clk, .arst_n, .start(fin_start_q), .rs,
		.mode_valid(mode_valid_q), .mode_code(best_code_q), .done(fin_done),
		.res(fin_res));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pre_end_q <= '0;
			gfirst_q <= '0;
			gfinal_q <= 14'h3FFF;
			tstep_q <= 24'h010000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMode:      mode_q <= cfg_data[0];
				RegPreEnd:    pre_end_q <= cfg_data[14:0];
				RegGateFirst: gfirst_q <= cfg_data[13:0];
				RegGateFinal: gfinal_q <= cfg_data[13:0];
				RegTimeStep:  tstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			sweep_q <= '0;
			inc_s1 <= 1'b0;
			inc_s2 <= 1'b0;
			inc_s3 <= 1'b0;
			scan_rd_s1 <= 1'b0;
			fin_start_q <= 1'b0;
			mode_valid_q <= 1'b0;
			m_tvalid <= 1'b0;
			idx_q <= '0;
			psum_q <= '0; gsum_q <= '0; pcnt_q <= '0; gcnt_q <= '0;
			vmin_q <= '0; vmax_q <= '0; imin_q <= '0; imax_q <= '0;
		end else begin
			fin_start_q <= 1'b0;
			inc_s1 <= acc && in_pre;
			addr_s1 <= raddr;
			inc_s2 <= inc_s1;
			addr_s2 <= addr_s1;
			val_s2 <= cur_s1 + 1'b1;
			inc_s3 <= inc_s2;
			addr_s3 <= addr_s2;
			val_s3 <= val_s2;
			scan_rd_s1 <= (st_q == S_SCAN) && !sweep_q[HistAw];
			scan_a_s1 <= sweep_q[HistAw-1:0];
			if (scan_rd_s1 && rdata > best_cnt_q) begin
				best_cnt_q <= rdata;
				best_code_q <= scan_a_s1;
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == (HistAw+1)'(HistDepth - 1)) st_q <= S_RUN;
				end
				S_RUN: if (acc) begin
					if (!idx_q[IdxBits]) begin
						idx_q <= idx_q + 1'b1;
						if (in_pre) begin
							psum_q <= psum_q + SumBits'(v);
							pcnt_q <= pcnt_q + 1'b1;
						end
						if (in_gate) begin
							gsum_q <= gsum_q + SumBits'(v);
							gcnt_q <= gcnt_q + 1'b1;
						end
						if (i == '0) begin
							vmin_q <= v; vmax_q <= v; imin_q <= '0; imax_q <= '0;
						end else begin
							if (v <= vmin_q) begin vmin_q <= v; imin_q <= i; end
							if (v >= vmax_q) begin vmax_q <= v; imax_q <= i; end
						end
					end
					if (s_tlast) begin
						st_q <= S_SCAN;
						sweep_q <= '0;
						best_cnt_q <= '0;
						best_code_q <= '0;
						mode_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// wait for the last increment to land before sweeping
					if (!inc_s1 && !inc_s2 && !sweep_q[HistAw])
						sweep_q <= sweep_q + 1'b1;
					if (sweep_q[HistAw] && !scan_rd_s1) begin
						st_q <= S_FIN;
						mode_valid_q <= 1'b1;
						fin_start_q <= 1'b1;
					end
				end
				S_FIN: if (fin_done) begin
					st_q <= S_OUT;
				end
				S_OUT: if (!m_tvalid) begin
					m_tvalid <= 1'b1;
					m_tdata <= fin_res;
					st_q <= S_RUN;
					idx_q <= '0;
					psum_q <= '0; gsum_q <= '0; pcnt_q <= '0; gcnt_q <= '0;
					vmin_q <= '0; vmax_q <= '0; imin_q <= '0; imax_q <= '0;
				end
				default: st_q <= S_CLR;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the waveform pulse analyzer.
// ---------------------------------------------------------------------------
// Records of signed samples are queued by the stimulus process and pushed
// onto the slave stream by a clocked driver. Every accepted transaction runs
// through a local record analyzer that produces the expected pulse summary at
// each record end. The clocked monitor checks each result transaction field by
// field against the oldest pending summary. Registers are rewritten only when
// the block is idle.
// ---------------------------------------------------------------------------
module tb;
	import wpa_pkg::*;

	// expected result of one record
	typedef struct packed {
		logic signed [15:0] baseline;
		logic [15:0]        amplitude;
		logic [13:0]        amp_idx;
		logic [11:0]        p2p;
		logic signed [55:0] integral;
		logic               empty;
	} pulse_summary_t;

	typedef struct packed {
		logic signed [11:0] sample;
		logic               last;
	} sample_item_t;

	localparam longint Int56Max = 64'h007F_FFFF_FFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = RegMode;
	logic [23:0]  cfg_data = '0;
	logic         s_tvalid, s_tready, s_tlast;
	logic [15:0]  s_tdata;
	logic         m_tvalid, m_tready;
	logic [119:0] m_tdata;

	always #5 clk = ~clk;

	waveform_pulse_analyzer u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// register shadows
	logic        sh_mode;
	logic [14:0] sh_pre_end;
	logic [13:0] sh_gate_first, sh_gate_final;
	logic [23:0] sh_tstep;

	// analyzer state for the record in flight
	int unsigned hist [HistDepth];
	int unsigned rec_idx, pre_cnt, gate_cnt;
	longint      pre_sum, gate_sum;
	int          vmin, vmax;
	int unsigned imin, imax;

	sample_item_t   pending_samples [$];
	pulse_summary_t expected_summaries [$];
	int src_idle, snk_idle;
	int errors, n_records, n_results, n_samples;

	// Feed one accepted sample; on record end push the expected summary.
	function automatic void analyze_sample(logic signed [11:0] s, logic last);
		pulse_summary_t r;
		longint base, dmn, dmx, sq4, mag, res;
		int unsigned best_cnt, best_code;
		int v;
		v = s;
		if (rec_idx < MaxPoints) begin
			if (rec_idx < sh_pre_end) begin
				pre_sum += v;
				pre_cnt++;
				hist[s + 2048]++;
			end
			if (rec_idx == 0) begin
				vmin = v; vmax = v; imin = 0; imax = 0;
			end else begin
				if (v <= vmin) begin vmin = v; imin = rec_idx; end
				if (v >= vmax) begin vmax = v; imax = rec_idx; end
			end
			if (rec_idx >= sh_gate_first && rec_idx <= sh_gate_final) begin
				gate_sum += v;
				gate_cnt++;
			end
			rec_idx++;
		end
		if (!last) return;

		// mode scan: strict greater keeps the smallest code on ties
		best_cnt = 0; best_code = 0;
		for (int k = 0; k < HistDepth; k++) begin
			if (hist[k] > best_cnt) begin best_cnt = hist[k]; best_code = k; end
			hist[k] = 0;
		end
		if (pre_cnt == 0) base = 0;
		else if (!sh_mode) base = (pre_sum * 16) / longint'(pre_cnt);
		else base = (longint'(best_code) - 2048) * 16;

		dmn = base - longint'(vmin) * 16;
		dmx = base - longint'(vmax) * 16;
		if (dmn < 0) dmn = -dmn;
		if (dmx < 0) dmx = -dmx;
		if (dmn > dmx) begin r.amplitude = dmn[15:0]; r.amp_idx = imin[13:0]; end
		else if (dmx > dmn) begin r.amplitude = dmx[15:0]; r.amp_idx = imax[13:0]; end
		else begin
			r.amplitude = dmx[15:0];
			r.amp_idx = (imin > imax) ? imin[13:0] : imax[13:0];
		end

		sq4 = longint'(gate_cnt) * base - gate_sum * 16;
		mag = (sq4 < 0) ? -sq4 : sq4;
		if (sh_tstep != 0 && mag > Int56Max / longint'(sh_tstep))
			res = (sq4 < 0) ? -Int56Max - 1 : Int56Max;
		else begin
			res = mag * longint'(sh_tstep);
			if (sq4 < 0) res = -res;
		end

		r.baseline = base[15:0];
		r.p2p = 12'(vmax - vmin);
		r.integral = res[55:0];
		r.empty = (pre_cnt == 0);
		expected_summaries.insert(expected_summaries.size(), r);
		n_records++;
		rec_idx = 0; pre_cnt = 0; gate_cnt = 0; pre_sum = 0; gate_sum = 0;
		vmin = 0; vmax = 0; imin = 0; imax = 0;
	endfunction

	// driver: take a new item when the slot is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				analyze_sample(s_tdata[11:0], s_tlast);
				n_samples++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_samples[0].sample};
					s_tlast <= pending_samples[0].last;
					void'(pending_samples.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: result transactions against pending summaries
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_summaries.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					pulse_summary_t e;
					pulse_summary_t a;
					e = expected_summaries.pop_front();
					a = {m_tdata[15:0], m_tdata[31:16], m_tdata[45:32], m_tdata[57:46],
						m_tdata[113:58], m_tdata[114]};
					if (a.baseline !== e.baseline) begin
						$error("baseline_q4 exp %0d got %0d", e.baseline, a.baseline); errors++;
					end
					if (a.amplitude !== e.amplitude) begin
						$error("amplitude_q4 exp %0d got %0d", e.amplitude, a.amplitude); errors++;
					end
					if (a.amp_idx !== e.amp_idx) begin
						$error("amplitude_index exp %0d got %0d", e.amp_idx, a.amp_idx); errors++;
					end
					if (a.p2p !== e.p2p) begin
						$error("peak_to_peak exp %0d got %0d", e.p2p, a.p2p); errors++;
					end
					if (a.integral !== e.integral) begin
						$error("gated_integral exp %0d got %0d", e.integral, a.integral); errors++;
					end
					if (a.empty !== e.empty) begin
						$error("pretrigger_empty exp %0d got %0d", e.empty, a.empty); errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegMode:      sh_mode = val[0];
			RegPreEnd:    sh_pre_end = val[14:0];
			RegGateFirst: sh_gate_first = val[13:0];
			RegGateFinal: sh_gate_final = val[13:0];
			RegTimeStep:  sh_tstep = val;
			default: ;
		endcase
	endtask

	task automatic write_all(logic m, int pe, int gf, int gl, int ts);
		write_reg(RegMode, 24'(m));
		write_reg(RegPreEnd, 24'(pe));
		write_reg(RegGateFirst, 24'(gf));
		write_reg(RegGateFinal, 24'(gl));
		write_reg(RegTimeStep, 24'(ts));
	endtask

	// Wait until every record is out, then let the block settle.
	task automatic drain();
		while (pending_samples.size() > 0 || s_tvalid || expected_summaries.size() > 0)
			@(posedge clk);
		repeat (4200) @(posedge clk);
	endtask

	task automatic push_sample(int v, logic last);
		sample_item_t it;
		it.sample = 12'(v);
		it.last = last;
		pending_samples.insert(pending_samples.size(), it);
	endtask

	// Random record: full-range noise, baseline with a pulse, few codes, flat.
	task automatic push_record(int len);
		int style, base, amp, pk, v;
		style = $urandom_range(3);
		base = int'($urandom_range(4095)) - 2048;
		amp = int'($urandom_range(4095)) - 2048;
		pk = $urandom_range(len - 1);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: v = int'($urandom_range(4095)) - 2048;
				1: v = (i >= pk && i < pk + 3) ? amp : base + int'($urandom_range(6)) - 3;
				2: v = base + 4 * int'($urandom_range(2));
				default: v = base;
			endcase
			if (v > 2047) v = 2047;
			if (v < -2048) v = -2048;
			push_sample(v, i == len - 1);
		end
	endtask

	initial begin
		int len, pe, gf, gl, ts;
		errors = 0; n_records = 0; n_results = 0; n_samples = 0;
		src_idle = 31; snk_idle = 71;
		sh_mode = 1'b0; sh_pre_end = 0; sh_gate_first = 0; sh_gate_final = 14'd16383;
		sh_tstep = 24'd65536;
		foreach (hist[k]) hist[k] = 0;
		rec_idx = 0; pre_cnt = 0; gate_cnt = 0; pre_sum = 0; gate_sum = 0;
		vmin = 0; vmax = 0; imin = 0; imax = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty pretrigger, extremes, one-sample record
		push_sample(-2048, 1'b1);
		push_sample(2047, 1'b1);
		push_sample(-2048, 1'b0); push_sample(2047, 1'b0); push_sample(0, 1'b1);
		drain();
		// average mode with negative sum (truncation toward zero), wide step
		write_all(1'b0, 3, 1, 4, 24'hFFFFFF);
		push_sample(-1, 1'b0); push_sample(-1, 1'b0); push_sample(-2, 1'b0);
		push_sample(5, 1'b0); push_sample(-5, 1'b1);
		drain();
		// mode with a tie between two codes, reversed gate
		write_all(1'b1, 4, 5, 2, 0);
		push_sample(7, 1'b0); push_sample(-3, 1'b0); push_sample(7, 1'b0);
		push_sample(-3, 1'b0); push_sample(2, 1'b0); push_sample(12, 1'b1);
		drain();

		// random phases
		for (int p = 0; p < 12; p++) begin
			if (p == 4) begin src_idle = 71; snk_idle = 31; end
			if (p == 8) begin src_idle = 0; snk_idle = 0; end
			pe = (p % 5 == 0) ? 16384 : int'($urandom_range(40));
			gf = (p % 6 == 1) ? 0 : int'($urandom_range(30));
			gl = (p % 6 == 2) ? 16383 : int'($urandom_range(40));
			case (p % 4)
				0: ts = 24'hFFFFFF;
				1: ts = 0;
				default: ts = $urandom_range(24'hFFFFFF);
			endcase
			write_all(p[0], pe, gf, gl, ts);
			for (int k = 0; k < 120;) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
				push_record(len);
				k += len;
			end
			drain();
		end

		$display("Covered %0d records, %0d samples, %0d results checked.",
			n_records, n_samples, n_results);
		if (errors == 0 && expected_summaries.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
